@@ hdl/fdwt53_pkg.sv @@
package fdwt53_pkg;

    localparam int COEF_BITS      = 18;
    localparam int INDEX_BITS     = 11;
    localparam int WIDTH_BITS     = 13;
    localparam int RESET_WIDTH    = 4096;
    localparam int MAX_RESULTS    = 3;
    localparam int FIFO_DEPTH     = 8;
    localparam int FIFO_PTR_BITS  = 3;
    localparam int FIFO_CNT_BITS  = 4;

    typedef struct packed {
        logic [COEF_BITS-1:0]  coefficient;
        logic                  band;
        logic [INDEX_BITS-1:0] band_index;
        logic                  line_end;
    } result_t;

endpackage

@@ hdl/forward_dwt53_line.sv @@
// A sample is held in the input register, then its results are written into the result queue.
// Throughput: one sample per cycle unless samples are held off; the eight-entry result queue
// drains one coefficient per cycle while result_stall is low, and holds off samples when it
// cannot take the beats of the registered sample plus three more.
// Reset clears the line position, the queue and the lifting state, and sets line_width to 4096.
module forward_dwt53_line #(
    parameter int MAX_LINE_WIDTH = 4096,
    parameter int SAMPLE_BITS    = 16
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 sample_valid,
    output logic                                 sample_stall,
    input  logic signed [SAMPLE_BITS-1:0]        sample,
    output logic                                 result_valid,
    input  logic                                 result_stall,
    output logic signed [fdwt53_pkg::COEF_BITS-1:0] coefficient,
    output logic                                 band,
    output logic [fdwt53_pkg::INDEX_BITS-1:0]    band_index,
    output logic                                 line_end,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [fdwt53_pkg::WIDTH_BITS-1:0]    line_width
);

    localparam int PW   = $clog2(MAX_LINE_WIDTH);
    localparam int CW   = SAMPLE_BITS + 2;
    localparam int WW   = (PW + 1 > fdwt53_pkg::WIDTH_BITS) ? PW + 1 : fdwt53_pkg::WIDTH_BITS;
    localparam int EXTW = (CW > fdwt53_pkg::COEF_BITS) ? CW : fdwt53_pkg::COEF_BITS;
    localparam int IW   = (PW > fdwt53_pkg::INDEX_BITS) ? PW : fdwt53_pkg::INDEX_BITS;

    function automatic logic [fdwt53_pkg::COEF_BITS-1:0] to_coef(input logic signed [CW-1:0] v);
        logic signed [EXTW-1:0] t;
        t = EXTW'(v);
        return t[fdwt53_pkg::COEF_BITS-1:0];
    endfunction

    function automatic logic [fdwt53_pkg::INDEX_BITS-1:0] to_index(input logic [PW-1:0] v);
        logic [IW-1:0] t;
        t = IW'(v);
        return t[fdwt53_pkg::INDEX_BITS-1:0];
    endfunction

    logic [fdwt53_pkg::WIDTH_BITS-1:0]    line_width_reg;
    logic                                 s1_valid_reg;
    logic signed [SAMPLE_BITS-1:0]        s1_sample_reg;
    logic [PW-1:0]                        pos_reg, pos_next;
    logic [PW-1:0]                        k_reg, k_next;
    logic signed [SAMPLE_BITS-1:0]        even_reg, even_next;
    logic signed [SAMPLE_BITS-1:0]        odd_reg, odd_next;
    logic signed [CW-1:0]                 prev_reg, prev_next;

    fdwt53_pkg::result_t                  fifo_mem [fdwt53_pkg::FIFO_DEPTH];
    logic [fdwt53_pkg::FIFO_PTR_BITS-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [fdwt53_pkg::FIFO_CNT_BITS-1:0] count_reg, count_next;

    fdwt53_pkg::result_t                  res [fdwt53_pkg::MAX_RESULTS];
    logic [1:0]                           push_n;
    logic                                 pop;
    logic                                 in_accept;
    logic                                 cfg_write;

    logic [WW-1:0]                        width_ext, width_clamp;
    logic [PW-1:0]                        last_pos;
    logic                                 at_end;

    logic signed [CW-1:0]                 xe, ee, oe;
    logic signed [CW-1:0]                 d_close, d_pred, d_sel;
    logic signed [CW-1:0]                 s_upd, s_first, s_tail;

    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;

    always_comb
    begin
        width_ext = WW'(line_width_reg);
        if (width_ext < WW'(3))
        begin
            width_clamp = WW'(3);
        end
        else if (width_ext > WW'(MAX_LINE_WIDTH))
        begin
            width_clamp = WW'(MAX_LINE_WIDTH);
        end
        else
        begin
            width_clamp = width_ext;
        end
        last_pos = PW'(width_clamp - WW'(1));
    end

    assign at_end = (pos_reg >= last_pos);

    assign xe      = CW'(s1_sample_reg);
    assign ee      = CW'(even_reg);
    assign oe      = CW'(odd_reg);
    assign d_close = xe - ee;
    assign d_pred  = oe - ((ee + xe) >>> 1);
    assign d_sel   = pos_reg[0] ? d_close : d_pred;
    assign s_upd   = ee + ((prev_reg + d_sel) >>> 2);
    assign s_first = ee + (d_pred >>> 1);
    assign s_tail  = xe + (d_pred >>> 1);

    always_comb
    begin
        pos_next  = pos_reg;
        k_next    = k_reg;
        even_next = even_reg;
        odd_next  = odd_reg;
        prev_next = prev_reg;
        push_n    = 2'd0;
        for (int i = 0; i < fdwt53_pkg::MAX_RESULTS; i++)
        begin
            res[i] = '0;
        end

        res[0].coefficient = to_coef(d_sel);
        res[0].band        = 1'b1;
        res[0].band_index  = to_index(k_reg);
        res[0].line_end    = 1'b0;
        res[1].coefficient = (!pos_reg[0] && k_reg == '0) ? to_coef(s_first) : to_coef(s_upd);
        res[1].band        = 1'b0;
        res[1].band_index  = to_index(k_reg);
        res[1].line_end    = pos_reg[0];
        res[2].coefficient = to_coef(s_tail);
        res[2].band        = 1'b0;
        res[2].band_index  = to_index(PW'(k_reg + PW'(1)));
        res[2].line_end    = 1'b1;

        if (s1_valid_reg)
        begin
            if (pos_reg == '0)
            begin
                even_next = s1_sample_reg;
                pos_next  = PW'(1);
            end
            else if (pos_reg[0])
            begin
                odd_next = s1_sample_reg;
                if (at_end)
                begin
                    push_n    = 2'd2;
                    pos_next  = '0;
                    k_next    = '0;
                    prev_next = '0;
                end
                else
                begin
                    pos_next = PW'(pos_reg + PW'(1));
                end
            end
            else
            begin
                even_next = s1_sample_reg;
                if (at_end)
                begin
                    push_n    = 2'd3;
                    pos_next  = '0;
                    k_next    = '0;
                    prev_next = '0;
                end
                else
                begin
                    push_n    = 2'd2;
                    pos_next  = PW'(pos_reg + PW'(1));
                    k_next    = PW'(k_reg + PW'(1));
                    prev_next = d_pred;
                end
            end
        end

        if (cfg_write)
        begin
            pos_next  = '0;
            k_next    = '0;
            prev_next = '0;
        end
    end

    // The queue must have room for the beats of the sample in the input register
    // and for the worst case of the sample taken now.
    assign sample_stall = (count_reg + fdwt53_pkg::FIFO_CNT_BITS'(push_n))
                          > fdwt53_pkg::FIFO_CNT_BITS'(fdwt53_pkg::FIFO_DEPTH
                                                       - fdwt53_pkg::MAX_RESULTS);
    assign in_accept    = sample_valid && !sample_stall;

    assign result_valid = (count_reg != '0);
    assign pop          = result_valid && !result_stall;
    assign count_next   = count_reg + fdwt53_pkg::FIFO_CNT_BITS'(push_n)
                          - fdwt53_pkg::FIFO_CNT_BITS'(pop);

    assign coefficient  = fifo_mem[rd_ptr_reg].coefficient;
    assign band         = fifo_mem[rd_ptr_reg].band;
    assign band_index   = fifo_mem[rd_ptr_reg].band_index;
    assign line_end     = fifo_mem[rd_ptr_reg].line_end;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_width_reg <= fdwt53_pkg::WIDTH_BITS'(fdwt53_pkg::RESET_WIDTH);
            s1_valid_reg   <= 1'b0;
            pos_reg        <= '0;
            k_reg          <= '0;
            even_reg       <= '0;
            odd_reg        <= '0;
            prev_reg       <= '0;
            wr_ptr_reg     <= '0;
            rd_ptr_reg     <= '0;
            count_reg      <= '0;
        end
        else
        begin
            if (cfg_write)
            begin
                line_width_reg <= line_width;
            end
            s1_valid_reg <= in_accept;
            pos_reg      <= pos_next;
            k_reg        <= k_next;
            even_reg     <= even_next;
            odd_reg      <= odd_next;
            prev_reg     <= prev_next;
            wr_ptr_reg   <= fdwt53_pkg::FIFO_PTR_BITS'(wr_ptr_reg
                                                       + fdwt53_pkg::FIFO_PTR_BITS'(push_n));
            rd_ptr_reg   <= fdwt53_pkg::FIFO_PTR_BITS'(rd_ptr_reg
                                                       + fdwt53_pkg::FIFO_PTR_BITS'(pop));
            count_reg    <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_sample_reg <= sample;
        end
        for (int i = 0; i < fdwt53_pkg::MAX_RESULTS; i++)
        begin
            if (2'(i) < push_n)
            begin
                fifo_mem[fdwt53_pkg::FIFO_PTR_BITS'(wr_ptr_reg
                         + fdwt53_pkg::FIFO_PTR_BITS'(i))] <= res[i];
            end
        end
    end

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= fdwt53_pkg::FIFO_CNT_BITS'(fdwt53_pkg::FIFO_DEPTH))
        else $error("Result queue count exceeds its depth.");

    a_stall_needs_fill: assert property (@(posedge clk) disable iff (!rst_n)
        sample_stall |-> (count_reg >= fdwt53_pkg::FIFO_CNT_BITS'(2)))
        else $error("Samples held off while the result queue is nearly empty.");

    a_end_is_smooth: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && line_end) |-> !band)
        else $error("Line end flagged on a detail coefficient.");

    a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= last_pos)
        else $error("Line position ran past the last sample of the line.");
`endif

endmodule

@@ test/dwt53_line_checker.sv @@
`timescale 1ns / 1ps

module dwt53_line_checker
(
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    sample_valid,
    input  logic                                    sample_stall,
    input  logic signed [15:0]                      sample,
    input  logic                                    result_valid,
    input  logic                                    result_stall,
    input  logic signed [fdwt53_pkg::COEF_BITS-1:0] coefficient,
    input  logic                                    band,
    input  logic [fdwt53_pkg::INDEX_BITS-1:0]       band_index,
    input  logic                                    line_end,
    input  logic                                    cfg_valid,
    input  logic                                    cfg_ready,
    input  logic [fdwt53_pkg::WIDTH_BITS-1:0]       line_width,
    output int                                      mismatches,
    output int                                      pending
);

    localparam logic BAND_LOW  = 1'b0;
    localparam logic BAND_HIGH = 1'b1;
    localparam int   MAX_WIDTH = 4096;

    fdwt53_pkg::result_t coef_queue[$];

    logic [fdwt53_pkg::WIDTH_BITS-1:0] width_reg;
    int line_pos;
    int even_x;
    int odd_x;
    int last_detail;
    int detail_idx;
    int error_count;

    function automatic int active_width();
        if (width_reg < 3)
        begin
            return 3;
        end
        if (width_reg > MAX_WIDTH)
        begin
            return MAX_WIDTH;
        end
        return int'(width_reg);
    endfunction

    function automatic void queue_coef(int value, logic which_band, int idx, logic last);
        fdwt53_pkg::result_t r;
        r.coefficient = fdwt53_pkg::COEF_BITS'(value);
        r.band        = which_band;
        r.band_index  = fdwt53_pkg::INDEX_BITS'(idx);
        r.line_end    = last;
        coef_queue.push_back(r);
    endfunction

    function automatic void restart_line();
        line_pos    = 0;
        detail_idx  = 0;
        last_detail = 0;
    endfunction

    function automatic void lift_sample(int x);
        int w;
        int d;
        int s;
        int k;
        w = active_width();
        if (line_pos == 0)
        begin
            even_x   = x;
            line_pos = 1;
        end
        else if (line_pos % 2 == 1)
        begin
            odd_x = x;
            if (line_pos >= w - 1)
            begin
                // Even width: the right edge mirrors the last even sample.
                d = x - even_x;
                s = even_x + ((last_detail + d) >>> 2);
                queue_coef(d, BAND_HIGH, detail_idx, 1'b0);
                queue_coef(s, BAND_LOW, detail_idx, 1'b1);
                restart_line();
            end
            else
            begin
                line_pos++;
            end
        end
        else
        begin
            k = detail_idx;
            d = odd_x - ((even_x + x) >>> 1);
            if (k == 0)
            begin
                s = even_x + (d >>> 1);
            end
            else
            begin
                s = even_x + ((last_detail + d) >>> 2);
            end
            queue_coef(d, BAND_HIGH, k, 1'b0);
            queue_coef(s, BAND_LOW, k, 1'b0);
            last_detail = d;
            detail_idx  = k + 1;
            even_x      = x;
            if (line_pos >= w - 1)
            begin
                // Odd width: the closing smooth value mirrors the last detail.
                queue_coef(x + (d >>> 1), BAND_LOW, k + 1, 1'b1);
                restart_line();
            end
            else
            begin
                line_pos++;
            end
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        fdwt53_pkg::result_t got;
        fdwt53_pkg::result_t want;
        if (!rst_n)
        begin
            width_reg   = fdwt53_pkg::WIDTH_BITS'(fdwt53_pkg::RESET_WIDTH);
            even_x      = 0;
            odd_x       = 0;
            error_count = 0;
            restart_line();
            coef_queue.delete();
            mismatches <= 0;
            pending    <= 0;
        end
        else
        begin
            if (result_valid && !result_stall)
            begin
                got.coefficient = coefficient;
                got.band        = band;
                got.band_index  = band_index;
                got.line_end    = line_end;
                if (coef_queue.size() == 0)
                begin
                    error_count++;
                    $display("%0t: unexpected beat, actual coef=%0d band=%0d idx=%0d end=%0d",
                             $time, $signed(got.coefficient), got.band, got.band_index,
                             got.line_end);
                end
                else
                begin
                    want = coef_queue.pop_front();
                    if (got.coefficient !== want.coefficient || got.band !== want.band ||
                        got.band_index !== want.band_index || got.line_end !== want.line_end)
                    begin
                        error_count++;
                        $display("%0t: mismatch, expected coef=%0d band=%0d idx=%0d end=%0d",
                                 $time, $signed(want.coefficient), want.band,
                                 want.band_index, want.line_end);
                        $display("%0t:           actual coef=%0d band=%0d idx=%0d end=%0d",
                                 $time, $signed(got.coefficient), got.band,
                                 got.band_index, got.line_end);
                    end
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                width_reg = line_width;
                restart_line();
            end
            if (sample_valid && !sample_stall)
            begin
                lift_sample(int'(sample));
            end
            mismatches <= error_count;
            pending    <= coef_queue.size();
        end
    end

endmodule

@@ test/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;

    localparam int SAMPLE_BITS  = 16;
    localparam int RANDOM_ITEMS = 440;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int MAX_WIDTH    = 4096;

    logic clk = 1'b0;
    logic rst_n;
    logic sample_valid;
    logic sample_stall;
    logic signed [SAMPLE_BITS-1:0] sample;
    logic result_valid;
    logic result_stall = 1'b0;
    logic signed [fdwt53_pkg::COEF_BITS-1:0] coefficient;
    logic band;
    logic [fdwt53_pkg::INDEX_BITS-1:0] band_index;
    logic line_end;
    logic cfg_valid;
    logic cfg_ready;
    logic [fdwt53_pkg::WIDTH_BITS-1:0] line_width;

    int mismatches;
    int pending;
    int cycle_count = 0;
    int stall_left = 0;
    bit idling = 1'b1;

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    forward_dwt53_line #(
        .MAX_LINE_WIDTH(MAX_WIDTH),
        .SAMPLE_BITS(SAMPLE_BITS)
    ) DUT (
        .clk(clk),
        .rst_n(rst_n),
        .sample_valid(sample_valid),
        .sample_stall(sample_stall),
        .sample(sample),
        .result_valid(result_valid),
        .result_stall(result_stall),
        .coefficient(coefficient),
        .band(band),
        .band_index(band_index),
        .line_end(line_end),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .line_width(line_width)
    );

    dwt53_line_checker line_checker (
        .clk(clk),
        .rst_n(rst_n),
        .sample_valid(sample_valid),
        .sample_stall(sample_stall),
        .sample(sample),
        .result_valid(result_valid),
        .result_stall(result_stall),
        .coefficient(coefficient),
        .band(band),
        .band_index(band_index),
        .line_end(line_end),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .line_width(line_width),
        .mismatches(mismatches),
        .pending(pending)
    );

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    // Receiver holds off in short random bursts while idling is enabled.
    always @(posedge clk)
    begin
        logic stall_next;
        stall_next = 1'b0;
        if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            stall_next = 1'b1;
        end
        else if (idling && $urandom_range(0, 3) == 0)
        begin
            stall_left <= $urandom_range(0, 2);
            stall_next = 1'b1;
        end
        result_stall <= stall_next;
    end

    function automatic int active_width(logic [fdwt53_pkg::WIDTH_BITS-1:0] w);
        if (w < 3)
        begin
            return 3;
        end
        if (w > MAX_WIDTH)
        begin
            return MAX_WIDTH;
        end
        return int'(w);
    endfunction

    function automatic logic signed [SAMPLE_BITS-1:0] pick_sample();
        logic [31:0] r;
        r = $urandom;
        case ($urandom_range(0, 7))
            0: return 16'sh8000;
            1: return 16'sh7FFF;
            2: return 16'sh0000;
            3: return 16'shFFFF;
            default: return r[15:0];
        endcase
    endfunction

    task automatic put_sample(input logic signed [SAMPLE_BITS-1:0] v);
        if (idling && $urandom_range(0, 3) == 0)
        begin
            sample_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        sample_valid <= 1'b1;
        sample       <= v;
        do
        begin
            @(posedge clk);
        end
        while (sample_stall);
    endtask

    task automatic wait_drained();
        sample_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
        begin
            @(posedge clk);
        end
        repeat (4) @(posedge clk);
    endtask

    task automatic write_width(input logic [fdwt53_pkg::WIDTH_BITS-1:0] w);
        wait_drained();
        cfg_valid  <= 1'b1;
        line_width <= w;
        do
        begin
            @(posedge clk);
        end
        while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    initial
    begin
        int sent;
        int n;
        int w;
        bit paused;
        logic [fdwt53_pkg::WIDTH_BITS-1:0] wr;

        rst_n        <= 1'b0;
        sample_valid <= 1'b0;
        sample       <= '0;
        cfg_valid    <= 1'b0;
        line_width   <= '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // At the reset width, a partial line is abandoned by the next write.
        put_sample(16'sh7FFF);
        put_sample(16'sh8000);
        put_sample(16'sh7FFF);

        write_width(0);
        put_sample(16'sh8000);
        put_sample(16'sh7FFF);
        put_sample(16'sh8000);
        put_sample(16'sh7FFF);
        put_sample(16'sh8000);
        put_sample(16'sh7FFF);

        write_width(4);
        put_sample(16'sh0000);
        put_sample(16'shFFFF);
        put_sample(16'sh8000);
        put_sample(16'sh7FFF);

        write_width(5);
        repeat (5) put_sample(16'shFFFF);
        put_sample(16'sh7FFF);
        put_sample(16'sh8000);

        sent   = 0;
        paused = 1'b0;
        while (sent < RANDOM_ITEMS)
        begin
            case ($urandom_range(0, 9))
                0: wr = $urandom_range(0, 2);
                1: wr = $urandom_range(0, 1) ? 13'h1FFF : $urandom_range(MAX_WIDTH - 1, 8190);
                2: wr = $urandom_range(25, 120);
                default: wr = $urandom_range(3, 24);
            endcase
            write_width(wr);
            w      = active_width(wr);
            idling = ($urandom_range(0, 3) != 0);
            if (w > 200)
            begin
                n = $urandom_range(1, 40);
            end
            else
            begin
                n = $urandom_range(1, 4) * w;
                if ($urandom_range(0, 2) == 0)
                begin
                    n += $urandom_range(1, w - 1);
                end
            end
            if (n > RANDOM_ITEMS - sent)
            begin
                n = RANDOM_ITEMS - sent;
            end
            repeat (n)
            begin
                put_sample(pick_sample());
                sent++;
                if (!paused && sent > RANDOM_ITEMS / 2)
                begin
                    paused = 1'b1;
                    wait_drained();
                end
            end
        end

        // Three full lines of an odd width, with no idling on either side.
        idling = 1'b0;
        write_width(17);
        repeat (3 * 17) put_sample(pick_sample());

        wait_drained();
        repeat (16) @(posedge clk);
        if (mismatches == 0 && pending == 0)
        begin
            $display("PASS");
        end
        else
        begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

@@ forward_dwt53_line.f @@
hdl/fdwt53_pkg.sv
hdl/forward_dwt53_line.sv
test/dwt53_line_checker.sv
test/tb_top.sv
